>>> src/decimal_tlv_field_parser_unit_macros.svh
// Assertion macros shared by the decimal TLV field parser unit.
`ifndef DECIMAL_TLV_FIELD_PARSER_UNIT_MACROS_SVH
`define DECIMAL_TLV_FIELD_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define DTLV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define DTLV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/dtlv_pkg.sv
// Types and constants of the decimal TLV field parser unit.
package dtlv_pkg;

    // One input beat: a character and the end-of-string mark.
    typedef struct packed {
        logic [7:0] char_byte;
        logic       string_end;
    } t_in_beat;

    // One result beat.
    typedef struct packed {
        logic       result_kind;
        logic [6:0] tag_number;
        logic [7:0] value_byte;
        logic       value_end;
        logic       fields_valid;
        logic       run_last;
    } t_out_beat;

    // Results produced by one parsed character, in delivery order.
    typedef struct packed {
        logic [1:0] count;
        t_out_beat  first;
        t_out_beat  second;
    } t_push;

    // Parse phases.
    typedef enum logic [1:0] {
        PH_TAG,
        PH_LEN,
        PH_VAL,
        PH_STOP
    } t_phase;

    // Result kinds.
    localparam logic RK_VALUE   = 1'b0;
    localparam logic RK_VERDICT = 1'b1;

    // Push counts.
    localparam logic [1:0] PUSH_NONE = 2'd0;
    localparam logic [1:0] PUSH_ONE  = 2'd1;
    localparam logic [1:0] PUSH_TWO  = 2'd2;

    // Field widths.
    localparam int unsigned TAG_W = 7;
    localparam int unsigned LEN_W = 10;

    // ASCII digit range.
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    // Known tags: a contiguous range plus one extra tag.
    localparam logic [6:0] TAG_KNOWN_LO = 7'd2;
    localparam logic [6:0] TAG_KNOWN_HI = 7'd8;
    localparam logic [6:0] TAG_EXTRA    = 7'd52;
    localparam logic [6:0] TAG_UNKNOWN  = 7'd1;

    // Tags whose lengths are checked, and the lengths they must carry.
    localparam int unsigned NUM_SLOTS = 3;
    localparam logic [6:0] TAG_SLOT0  = 7'd2;
    localparam logic [6:0] TAG_SLOT1  = 7'd3;
    localparam logic [6:0] TAG_SLOT2  = 7'd8;
    localparam logic [9:0] REQ_LEN0   = 10'd14;
    localparam logic [9:0] REQ_LEN1   = 10'd15;
    localparam logic [9:0] REQ_LEN2   = 10'd4;

    // Default depth of the result queue.
    localparam int unsigned QUEUE_DEPTH = 4;

endpackage

>>> src/dtlv_parser.sv
// Parse state machine: turns one character into zero, one or two result beats.
module dtlv_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  dtlv_pkg::t_in_beat i_beat,
    output dtlv_pkg::t_push    o_push
);

    // Parse state.
    dtlv_pkg::t_phase                  r_phase, n_phase;
    logic [1:0]                        r_digit_count, n_digit_count;
    logic                              r_leading, n_leading;
    logic [dtlv_pkg::TAG_W-1:0]        r_tag, n_tag;
    logic [dtlv_pkg::LEN_W-1:0]        r_len, n_len;
    logic [dtlv_pkg::LEN_W-1:0]        r_rem, n_rem;
    logic [dtlv_pkg::LEN_W-1:0]        r_seen [dtlv_pkg::NUM_SLOTS];
    logic [dtlv_pkg::LEN_W-1:0]        n_seen [dtlv_pkg::NUM_SLOTS];
    logic [dtlv_pkg::LEN_W-1:0]        w_seen_upd [dtlv_pkg::NUM_SLOTS];

    logic                              w_isdig;
    logic [3:0]                        w_digit;
    logic [dtlv_pkg::TAG_W-1:0]        w_tag_mac;
    logic [dtlv_pkg::LEN_W-1:0]        w_len_mac;
    logic                              w_known;
    logic                              w_emit_value;
    logic                              w_ok;
    logic                              w_record;
    logic [dtlv_pkg::LEN_W-1:0]        w_record_len;
    dtlv_pkg::t_out_beat               w_value_beat;
    dtlv_pkg::t_out_beat               w_verdict_beat;

    // Digit decode and decimal accumulation.
    assign w_isdig   = (i_beat.char_byte >= dtlv_pkg::CHAR_ZERO) &&
                       (i_beat.char_byte <= dtlv_pkg::CHAR_NINE);
    assign w_digit   = 4'(i_beat.char_byte - dtlv_pkg::CHAR_ZERO);
    assign w_tag_mac = 7'(r_tag * 7'd10) + 7'(w_digit);
    assign w_len_mac = 10'(r_len * 10'd10) + 10'(w_digit);
    assign w_known   = ((r_tag >= dtlv_pkg::TAG_KNOWN_LO) && (r_tag <= dtlv_pkg::TAG_KNOWN_HI)) ||
                       (r_tag == dtlv_pkg::TAG_EXTRA);

    // Next state.
    always_comb begin
        n_phase       = r_phase;
        n_digit_count = r_digit_count;
        n_leading     = r_leading;
        n_tag         = r_tag;
        n_len         = r_len;
        n_rem         = r_rem;
        w_record      = 1'b0;
        w_record_len  = r_len;
        unique case (r_phase)
            dtlv_pkg::PH_TAG: begin
                if (w_isdig && r_leading) begin
                    n_tag = w_tag_mac;
                end else begin
                    n_leading = 1'b0;
                end
                n_digit_count = r_digit_count + 2'd1;
                if (r_digit_count >= 2'd1) begin
                    if (n_tag == '0) begin
                        n_phase = dtlv_pkg::PH_STOP;
                    end else begin
                        if (!n_leading) begin
                            n_tag = dtlv_pkg::TAG_UNKNOWN;
                        end
                        n_phase       = dtlv_pkg::PH_LEN;
                        n_digit_count = 2'd0;
                        n_leading     = 1'b1;
                        n_len         = '0;
                    end
                end
            end
            dtlv_pkg::PH_LEN: begin
                if (w_isdig && r_leading) begin
                    n_len = w_len_mac;
                end else begin
                    n_leading = 1'b0;
                end
                n_digit_count = r_digit_count + 2'd1;
                if (r_digit_count >= 2'd2) begin
                    if (n_len == '0) begin
                        // Empty value: record it and start the next record.
                        w_record      = 1'b1;
                        w_record_len  = '0;
                        n_phase       = dtlv_pkg::PH_TAG;
                        n_digit_count = 2'd0;
                        n_leading     = 1'b1;
                        n_tag         = '0;
                        n_len         = '0;
                        n_rem         = '0;
                    end else begin
                        n_rem         = n_len;
                        n_phase       = dtlv_pkg::PH_VAL;
                        n_digit_count = 2'd0;
                    end
                end
            end
            dtlv_pkg::PH_VAL: begin
                n_rem = (r_rem != '0) ? r_rem - 10'd1 : '0;
                if (n_rem == '0) begin
                    w_record      = 1'b1;
                    w_record_len  = r_len;
                    n_phase       = dtlv_pkg::PH_TAG;
                    n_digit_count = 2'd0;
                    n_leading     = 1'b1;
                    n_tag         = '0;
                    n_len         = '0;
                end
            end
            dtlv_pkg::PH_STOP: begin
                n_phase = r_phase;
            end
            default: begin
                n_phase = dtlv_pkg::PH_STOP;
            end
        endcase

        // Recorded lengths of the checked tags.
        for (int i = 0; i < dtlv_pkg::NUM_SLOTS; i++) begin
            w_seen_upd[i] = r_seen[i];
        end
        if (w_record) begin
            if (r_tag == dtlv_pkg::TAG_SLOT0) w_seen_upd[0] = w_record_len;
            if (r_tag == dtlv_pkg::TAG_SLOT1) w_seen_upd[1] = w_record_len;
            if (r_tag == dtlv_pkg::TAG_SLOT2) w_seen_upd[2] = w_record_len;
        end

        // The last character of a string returns everything to reset.
        for (int i = 0; i < dtlv_pkg::NUM_SLOTS; i++) begin
            n_seen[i] = i_beat.string_end ? '0 : w_seen_upd[i];
        end
        if (i_beat.string_end) begin
            n_phase       = dtlv_pkg::PH_TAG;
            n_digit_count = 2'd0;
            n_leading     = 1'b1;
            n_tag         = '0;
            n_len         = '0;
            n_rem         = '0;
        end
    end

    // Result beats.
    always_comb begin
        w_emit_value = (r_phase == dtlv_pkg::PH_VAL) && w_known;
        w_ok         = (w_seen_upd[0] == dtlv_pkg::REQ_LEN0) &&
                       (w_seen_upd[1] == dtlv_pkg::REQ_LEN1) &&
                       (w_seen_upd[2] == dtlv_pkg::REQ_LEN2);

        w_value_beat              = '0;
        w_value_beat.result_kind  = dtlv_pkg::RK_VALUE;
        w_value_beat.tag_number   = r_tag;
        w_value_beat.value_byte   = i_beat.char_byte;
        w_value_beat.value_end    = (r_rem <= 10'd1);
        w_value_beat.run_last     = !i_beat.string_end;

        w_verdict_beat              = '0;
        w_verdict_beat.result_kind  = dtlv_pkg::RK_VERDICT;
        w_verdict_beat.fields_valid = w_ok;
        w_verdict_beat.run_last     = 1'b1;

        o_push = '0;
        if (i_go) begin
            if (w_emit_value && i_beat.string_end) begin
                o_push.count  = dtlv_pkg::PUSH_TWO;
                o_push.first  = w_value_beat;
                o_push.second = w_verdict_beat;
            end else if (w_emit_value) begin
                o_push.count = dtlv_pkg::PUSH_ONE;
                o_push.first = w_value_beat;
            end else if (i_beat.string_end) begin
                o_push.count = dtlv_pkg::PUSH_ONE;
                o_push.first = w_verdict_beat;
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= dtlv_pkg::PH_TAG;
            r_digit_count <= 2'd0;
            r_leading     <= 1'b1;
            r_tag         <= '0;
            r_len         <= '0;
            r_rem         <= '0;
            for (int i = 0; i < dtlv_pkg::NUM_SLOTS; i++) begin
                r_seen[i] <= '0;
            end
        end else if (i_go) begin
            r_phase       <= n_phase;
            r_digit_count <= n_digit_count;
            r_leading     <= n_leading;
            r_tag         <= n_tag;
            r_len         <= n_len;
            r_rem         <= n_rem;
            for (int i = 0; i < dtlv_pkg::NUM_SLOTS; i++) begin
                r_seen[i] <= n_seen[i];
            end
        end
    end

endmodule

>>> src/dtlv_result_queue.sv
// Small result queue: takes up to two beats a cycle, delivers one while not stalled.
module dtlv_result_queue #(
    parameter int unsigned DEPTH = dtlv_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dtlv_pkg::t_push     i_push,
    output logic                o_room,
    output logic                o_valid,
    input  logic                i_stall,
    output dtlv_pkg::t_out_beat o_data
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    dtlv_pkg::t_out_beat r_mem [DEPTH];
    logic [PW-1:0]       r_wr, n_wr;
    logic [PW-1:0]       r_rd, n_rd;
    logic [CW-1:0]       r_count, n_count;
    logic                w_pop;
    logic [PW-1:0]       w_wr_next;

    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] p);
        logic [PW-1:0] q;
        q = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
        return q;
    endfunction

    // Room for a full two-beat push, judged from registered state only.
    assign o_room    = (r_count <= CW'(DEPTH - 2));
    assign o_valid   = (r_count != '0);
    assign o_data    = r_mem[r_rd];
    assign w_pop     = o_valid && !i_stall;
    assign w_wr_next = f_inc(r_wr);

    // Pointer and fill count updates.
    always_comb begin
        n_rd    = w_pop ? f_inc(r_rd) : r_rd;
        n_count = r_count + CW'(i_push.count) - CW'(w_pop);
        unique case (i_push.count)
            dtlv_pkg::PUSH_ONE: n_wr = w_wr_next;
            dtlv_pkg::PUSH_TWO: n_wr = f_inc(w_wr_next);
            default:            n_wr = r_wr;
        endcase
    end

    // Storage writes.
    always_ff @(posedge i_clk) begin
        if (i_push.count != dtlv_pkg::PUSH_NONE) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.count == dtlv_pkg::PUSH_TWO) begin
            r_mem[w_wr_next] <= i_push.second;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

>>> src/decimal_tlv_field_parser_unit.sv
// Top level of the decimal TLV field parser unit.
// The unit accepts one string character per cycle and parses records of a
// two-digit tag, a three-digit length and that many value bytes. Each beat
// accepted is held in an input register, parsed once the result queue has
// room and its results written to the result queue, which offers them on the
// output. A character gives at most one result, except the last character
// of a string that is also a value byte of a known tag, which gives two; the
// queue delivers one result beat a cycle while the output is not stalled, so
// sustained rate is one character per cycle plus one extra output beat for
// each such string end. The input side stalls only while the result queue
// lacks room for two beats.
`include "decimal_tlv_field_parser_unit_macros.svh"

module decimal_tlv_field_parser_unit #(
    parameter int unsigned QUEUE_DEPTH = dtlv_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dtlv_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dtlv_pkg::t_out_beat o_out_data
);

    logic               r_in_valid, n_in_valid;
    dtlv_pkg::t_in_beat r_in;
    logic               w_room;
    logic               w_go;
    dtlv_pkg::t_push    w_push;

    // Input register: advances whenever the queue can take a full push.
    assign w_go       = r_in_valid && w_room;
    assign o_in_stall = r_in_valid && !w_room;

    always_comb begin
        if (i_in_valid && !o_in_stall) begin
            n_in_valid = 1'b1;
        end else if (w_go) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    // Parse state machine.
    dtlv_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_beat  (r_in),
        .o_push  (w_push)
    );

    // Result queue towards the output channel.
    dtlv_result_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

    // A character never yields more than two results.
    `DTLV_ASSERT_NOW(a_push_count, 1'b1, w_push.count != 2'd3, "more than two results pushed")
    // A double push is always a value byte followed by the verdict.
    `DTLV_ASSERT_NOW(a_double_order, w_push.count == dtlv_pkg::PUSH_TWO, (w_push.first.result_kind == dtlv_pkg::RK_VALUE) && (w_push.second.result_kind == dtlv_pkg::RK_VERDICT) && !w_push.first.run_last && w_push.second.run_last, "double push out of order")
    // A single push carries the last-result mark.
    `DTLV_ASSERT_NOW(a_single_last, w_push.count == dtlv_pkg::PUSH_ONE, w_push.first.run_last, "single result without last mark")
    // A held character stays held until the queue has room.
    `DTLV_ASSERT_NEXT(a_hold_in, r_in_valid && !w_room, r_in_valid, "held character lost")

endmodule

>>> tb/sv/dtlv_parse_checker.sv
// Checker for the decimal TLV field parser unit: predicts every result beat and compares it.
module dtlv_parse_checker
    import dtlv_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_beat  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_beat i_out_data,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_value_beats,
    output int        o_verdicts,
    output int        o_verdicts_ok
);

    // Parser state of the prediction.
    t_phase     phase;
    logic [1:0] digit_cnt;
    logic       leading;
    logic [6:0] tag_acc;
    logic [9:0] len_acc;
    logic [9:0] bytes_left;
    logic [9:0] recorded_len [NUM_SLOTS];

    // Result beats predicted but not yet delivered, oldest first.
    t_out_beat  pending_results [$];
    t_out_beat  oldest;

    initial begin
        o_fail_count  = 0;
        o_pending     = 0;
        o_value_beats = 0;
        o_verdicts    = 0;
        o_verdicts_ok = 0;
    end

    // Return to the start of a record.
    task automatic clear_record();
        phase      = PH_TAG;
        digit_cnt  = '0;
        leading    = 1'b1;
        tag_acc    = '0;
        len_acc    = '0;
        bytes_left = '0;
    endtask

    // Only the checked tags keep the length of their last complete value.
    task automatic note_length(input logic [6:0] tag, input logic [9:0] len);
        case (tag)
            TAG_SLOT0: recorded_len[0] = len;
            TAG_SLOT1: recorded_len[1] = len;
            TAG_SLOT2: recorded_len[2] = len;
            default: ;
        endcase
    endtask

    // Advance the prediction by one accepted character and queue its results.
    task automatic parse_char(input t_in_beat beat);
        logic      is_digit;
        logic      last_value;
        logic      verdict_ok;
        t_out_beat res;
        is_digit = (beat.char_byte >= CHAR_ZERO) && (beat.char_byte <= CHAR_NINE);
        case (phase)
            PH_TAG: begin
                if (is_digit && leading) begin
                    tag_acc = tag_acc * 7'd10 + 7'(beat.char_byte - CHAR_ZERO);
                end else begin
                    leading = 1'b0;
                end
                digit_cnt = digit_cnt + 2'd1;
                if (digit_cnt == 2'd2) begin
                    if (tag_acc == '0) begin
                        phase = PH_STOP;
                    end else begin
                        // A tag broken by a non-digit counts as unknown.
                        if (!leading) begin
                            tag_acc = TAG_UNKNOWN;
                        end
                        phase     = PH_LEN;
                        digit_cnt = '0;
                        leading   = 1'b1;
                        len_acc   = '0;
                    end
                end
            end
            PH_LEN: begin
                if (is_digit && leading) begin
                    len_acc = len_acc * 10'd10 + 10'(beat.char_byte - CHAR_ZERO);
                end else begin
                    leading = 1'b0;
                end
                digit_cnt = digit_cnt + 2'd1;
                if (digit_cnt == 2'd3) begin
                    if (len_acc == '0) begin
                        note_length(tag_acc, '0);
                        clear_record();
                    end else begin
                        bytes_left = len_acc;
                        phase      = PH_VAL;
                        digit_cnt  = '0;
                    end
                end
            end
            PH_VAL: begin
                last_value = (bytes_left <= 10'd1);
                if ((tag_acc >= TAG_KNOWN_LO && tag_acc <= TAG_KNOWN_HI) ||
                    tag_acc == TAG_EXTRA) begin
                    res = '{result_kind: RK_VALUE, tag_number: tag_acc,
                            value_byte: beat.char_byte, value_end: last_value,
                            fields_valid: 1'b0, run_last: !beat.string_end};
                    pending_results.push_back(res);
                end
                if (bytes_left > '0) begin
                    bytes_left = bytes_left - 10'd1;
                end
                if (bytes_left == '0) begin
                    note_length(tag_acc, len_acc);
                    clear_record();
                end
            end
            default: ;
        endcase

        // The end of the string gives the verdict and clears everything.
        if (beat.string_end) begin
            verdict_ok = (recorded_len[0] == REQ_LEN0) && (recorded_len[1] == REQ_LEN1) &&
                         (recorded_len[2] == REQ_LEN2);
            res = '{result_kind: RK_VERDICT, tag_number: '0, value_byte: '0,
                    value_end: 1'b0, fields_valid: verdict_ok, run_last: 1'b1};
            pending_results.push_back(res);
            clear_record();
            for (int k = 0; k < NUM_SLOTS; k++) begin
                recorded_len[k] = '0;
            end
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    // Compare delivered beats first, then predict from the accepted character.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_record();
            for (int k = 0; k < NUM_SLOTS; k++) begin
                recorded_len[k] = '0;
            end
            pending_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result beat with no expectation: %h", i_out_data);
                    o_fail_count++;
                end else begin
                    oldest = pending_results.pop_front();
                    check_field("result_kind", oldest.result_kind, i_out_data.result_kind);
                    check_field("tag_number", oldest.tag_number, i_out_data.tag_number);
                    check_field("value_byte", oldest.value_byte, i_out_data.value_byte);
                    check_field("value_end", oldest.value_end, i_out_data.value_end);
                    check_field("fields_valid", oldest.fields_valid, i_out_data.fields_valid);
                    check_field("run_last", oldest.run_last, i_out_data.run_last);
                    if (oldest.result_kind == RK_VERDICT) begin
                        o_verdicts++;
                        if (oldest.fields_valid) begin
                            o_verdicts_ok++;
                        end
                    end else begin
                        o_value_beats++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                parse_char(i_in_data);
            end
        end
        o_pending = pending_results.size();
    end

endmodule

>>> tb/sv/tb_decimal_tlv_field_parser_unit.sv
// Testbench top of the decimal TLV field parser unit: string stimulus, flow control and verdict.
module tb_decimal_tlv_field_parser_unit;
    import dtlv_pkg::*;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_beat  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_beat o_out_data;

    int fail_count;
    int pending;
    int value_beats;
    int verdicts;
    int verdicts_ok;

    // Characters of the string being built, sent first to last.
    logic [7:0] frame_bytes [$];
    int         burst_left   = 0;
    int         strings_sent = 0;
    int         chars_sent   = 0;
    logic       stall_now    = 1'b0;
    int         stall_run    = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    decimal_tlv_field_parser_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    dtlv_parse_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_data    (o_out_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_value_beats (value_beats),
        .o_verdicts    (verdicts),
        .o_verdicts_ok (verdicts_ok)
    );

    // Result side: free runs, mostly short but now and then long, alternate with short stalls.
    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            if (stall_now) begin
                stall_now = 1'b0;
                stall_run = ($urandom_range(0, 15) == 0) ? $urandom_range(50, 200)
                                                         : $urandom_range(1, 12);
            end else begin
                stall_now = 1'b1;
                stall_run = $urandom_range(1, 6);
            end
        end
        stall_run--;
        i_out_stall <= stall_now;
    end

    // Offer one character beat and hold it until it is taken; gaps fall between bursts.
    task automatic send_char(input logic [7:0] chr, input logic last);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{char_byte: chr, string_end: last};
        burst_left--;
        do @(posedge i_clk); while (o_in_stall);
        chars_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_bytes[k]) begin
            send_char(frame_bytes[k], k == frame_bytes.size() - 1);
        end
        strings_sent++;
    endtask

    task automatic push_digits(input int value, input int count);
        int divisor;
        divisor = 1;
        repeat (count - 1) divisor = divisor * 10;
        repeat (count) begin
            frame_bytes.push_back(8'(CHAR_ZERO + (value / divisor) % 10));
            divisor = divisor / 10;
        end
    endtask

    function automatic logic [7:0] non_digit();
        logic [7:0] chr;
        do chr = 8'($urandom_range(0, 255)); while (chr >= CHAR_ZERO && chr <= CHAR_NINE);
        return chr;
    endfunction

    // A string of records, mostly well formed, with broken tags, broken
    // lengths, early stops and truncation mixed in.
    task automatic build_record_string();
        int n_rec;
        int pick;
        int tag;
        int len;
        int pos;
        frame_bytes.delete();
        n_rec = $urandom_range(1, 6);
        for (int r = 0; r < n_rec; r++) begin
            pick = $urandom_range(0, 99);
            if (pick >= 93) begin
                // Zero tag: the rest of the string is ignored.
                push_digits(0, 2);
                repeat ($urandom_range(0, 4)) frame_bytes.push_back(8'($urandom_range(0, 255)));
                break;
            end
            if (pick < 45) begin
                case ($urandom_range(0, 2))
                    0: begin tag = TAG_SLOT0; len = REQ_LEN0; end
                    1: begin tag = TAG_SLOT1; len = REQ_LEN1; end
                    default: begin tag = TAG_SLOT2; len = REQ_LEN2; end
                endcase
                if ($urandom_range(0, 9) >= 7) begin
                    len = $urandom_range(0, 20);
                end
                push_digits(tag, 2);
            end else if (pick < 70) begin
                tag = ($urandom_range(0, 5) == 0) ? TAG_EXTRA : $urandom_range(4, 7);
                len = $urandom_range(0, 8);
                push_digits(tag, 2);
            end else if (pick < 86) begin
                tag = $urandom_range(1, 99);
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(16, 120)
                                                   : $urandom_range(0, 8);
                push_digits(tag, 2);
            end else begin
                // Tag with a non-digit in it.
                frame_bytes.push_back(($urandom_range(0, 1) == 0) ? non_digit()
                                      : 8'(CHAR_ZERO + $urandom_range(1, 9)));
                frame_bytes.push_back(non_digit());
                len = $urandom_range(0, 6);
            end

            // Length field, now and then cut short by a non-digit.
            push_digits(len, 3);
            if ($urandom_range(0, 11) == 0) begin
                pos = frame_bytes.size() - 1 - $urandom_range(0, 2);
                frame_bytes[pos] = non_digit();
            end
            repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
        end

        // Truncate some strings inside a record.
        if ($urandom_range(0, 9) == 0 && frame_bytes.size() > 1) begin
            frame_bytes = frame_bytes[0:$urandom_range(0, frame_bytes.size() - 2)];
        end
    endtask

    task automatic build_noise_string();
        frame_bytes.delete();
        repeat ($urandom_range(1, 12)) begin
            frame_bytes.push_back(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255))
                                  : 8'(CHAR_ZERO + $urandom_range(0, 9)));
        end
    endtask

    // Guard against a hung run.
    initial begin
        #5_000_000;
        $display("tb_decimal_tlv_field_parser_unit NOT OK");
        $finish;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Known tag 2 of length 1 whose only value byte, all ones, ends the string.
        frame_bytes = '{"0", "2", "0", "0", "1", 8'hFF};
        send_frame();
        // Tag broken by a non-digit, length cut by a zero byte, zero tag, ignored tail.
        frame_bytes = '{"5", "a", "0", 8'h00, "9", "0", "0", "Q"};
        send_frame();
        // Unknown tag skipped, tag 52 with a zero value byte, string ending in a tag.
        frame_bytes = '{"9", "9", "0", "0", "1", "z", "5", "2", "0", "0", "2", 8'h00, "B", "0"};
        send_frame();

        while (chars_sent < 1600) begin
            if ($urandom_range(0, 9) == 0) begin
                build_noise_string();
            end else begin
                build_record_string();
            end
            send_frame();
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (pending == 0);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d strings of %0d characters in all.", strings_sent, chars_sent);
        $display("Checked %0d value beats and %0d verdicts, %0d of them passing.",
                 value_beats, verdicts, verdicts_ok);
        if (fail_count == 0) begin
            $display("tb_decimal_tlv_field_parser_unit OK");
        end else begin
            $display("tb_decimal_tlv_field_parser_unit NOT OK");
        end
        $finish;
    end

endmodule
